### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### rtl/etc_pkg.sv
// ----------------------------------------------------------------------------
// etc_pkg
// Types, codes and constants of the elementwise tensor combiner.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam int DATA_W            = 32;
    localparam int SRC_W             = 2;
    localparam int OP_W              = 3;
    localparam int CFG_INDEX_W       = 3;
    localparam int MAX_SOURCES_DEF   = 4;
    localparam int FRACTION_BITS_DEF = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_PROD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUM  = 3'd1;
    localparam logic [OP_W-1:0] OP_MAX  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_MIN  = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OPERATION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_0  = 3'd1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic [SRC_W-1:0]         source_index;
        logic                     channel_present;
        logic                     last_source;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_FIN,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

### rtl/etc_mul.sv
// ----------------------------------------------------------------------------
// etc_mul
// Registered 32x32 signed multiplier, full 64-bit product.
// ----------------------------------------------------------------------------
module etc_mul (
    input  logic                                    clk,
    input  logic signed [etc_pkg::DATA_W-1:0]       a,
    input  logic signed [etc_pkg::DATA_W-1:0]       b,
    output logic signed [2*etc_pkg::DATA_W-1:0]     product_reg
);
    import etc_pkg::*;

    logic signed [2*DATA_W-1:0] product_next;

    assign product_next = (2*DATA_W)'(a) * (2*DATA_W)'(b);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

endmodule

### rtl/etc_div.sv
// ----------------------------------------------------------------------------
// etc_div
// Radix-2 restoring divider: (dividend << FRACTION_BITS) / divisor, truncated
// toward zero and saturated to 32 bits. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module etc_div #(
    parameter int FRACTION_BITS = etc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [etc_pkg::DATA_W-1:0] dividend,
    input  logic signed [etc_pkg::DATA_W-1:0] divisor,
    output logic signed [etc_pkg::DATA_W-1:0] quotient,
    output etc_pkg::div_status_t              status
);
    import etc_pkg::*;

    localparam int NUM_W  = DATA_W + FRACTION_BITS;
    localparam int Q_BITS = DATA_W + 1;          // enough to see any overflow
    localparam int HI_W   = NUM_W - Q_BITS;
    localparam int CNT_W  = $clog2(Q_BITS + 1);
    localparam logic [Q_BITS-1:0] NEG_LIMIT = Q_BITS'(1) << (DATA_W - 1);

    logic [DATA_W-1:0] a_u, b_u, a_mag, b_mag;
    logic [NUM_W-1:0]  num_full;
    logic [HI_W-1:0]   num_hi;
    logic              ovf_start;

    logic [Q_BITS-1:0] rem_reg, rem_next;
    logic [Q_BITS-1:0] num_reg, num_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [Q_BITS-1:0] shifted, diff, neg_q;
    logic              ge, over;

    assign a_u      = dividend;
    assign b_u      = divisor;
    assign a_mag    = a_u[DATA_W-1] ? (~a_u + DATA_W'(1)) : a_u;
    assign b_mag    = b_u[DATA_W-1] ? (~b_u + DATA_W'(1)) : b_u;
    assign num_full = {a_mag, {FRACTION_BITS{1'b0}}};
    assign num_hi   = num_full[NUM_W-1:Q_BITS];
    // high part already at or above the divisor: quotient >= 2^33
    assign ovf_start = Q_BITS'(num_hi) >= Q_BITS'(b_mag);

    assign shifted = {rem_reg[Q_BITS-2:0], num_reg[Q_BITS-1]};
    assign ge      = shifted >= Q_BITS'(den_reg);
    assign diff    = shifted - Q_BITS'(den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = Q_BITS'(num_hi);
            num_next  = num_full[Q_BITS-1:0];
            den_next  = b_mag;
            neg_next  = a_u[DATA_W-1] ^ b_u[DATA_W-1];
            ovf_next  = ovf_start;
            cnt_next  = CNT_W'(Q_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : shifted;
            num_next = {num_reg[Q_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    // sign and clamp of the finished magnitude
    assign neg_q = Q_BITS'(0) - num_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            over     = ovf_reg || (num_reg > NEG_LIMIT);
            quotient = over ? Q_MIN : neg_q[DATA_W-1:0];
        end
        else
        begin
            over     = ovf_reg || (num_reg >= NEG_LIMIT);
            quotient = over ? Q_MAX : num_reg[DATA_W-1:0];
        end
    end

    assign status.done     = done_reg;
    assign status.overflow = over;

endmodule

### rtl/elementwise_tensor_combine.sv
// ----------------------------------------------------------------------------
// elementwise_tensor_combine
// Element-wise combiner of up to MAX_SOURCES source values, signed Q16.16.
// Source values for one output element arrive in order, one per transaction.
// A source 0 transaction loads the accumulator (weighted in sum mode) and
// clears the saturation flag; later present sources fold in by product,
// weighted sum, maximum, division or minimum. The transaction flagged
// last_source produces one result transaction with the accumulator and the
// flag. One transaction is processed at a time: load, max, min, divide by
// zero and skipped sources go through the start and emit states; product
// and weighted sum add a finish state (one registered 32x32 multiply, then
// round/add/saturate); division waits out 33 radix-2 restoring iterations.
// in_stall is low only while the sequencer is idle, so it stays high from the
// accepting edge until the transaction has been worked off. A result goes
// into the output register; if that register still holds an untaken result,
// the sequencer waits and in_stall stays high until the old one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elementwise_tensor_combine #(
    parameter int MAX_SOURCES   = etc_pkg::MAX_SOURCES_DEF,
    parameter int FRACTION_BITS = etc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [etc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [etc_pkg::DATA_W-1:0]             cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  etc_pkg::in_item_t                      in_data,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output etc_pkg::out_item_t                     out_data
);
    import etc_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam logic signed [DATA_W-1:0] ONE_Q    = DATA_W'(1) << FRACTION_BITS;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRACTION_BITS - 1);

    // configuration
    logic [OP_W-1:0]          op_reg, op_next;
    logic signed [DATA_W-1:0] weight_reg [MAX_SOURCES];
    logic signed [DATA_W-1:0] weight_next [MAX_SOURCES];

    // sequencer and item registers
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [SRC_W-1:0]         src_reg, src_next;
    logic                     present_reg, present_next;
    logic                     last_reg, last_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     sat_reg, sat_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    // decode
    logic                     in_accept, out_free, load_out;
    logic                     is_first, is_active;
    logic                     go_mul, go_div, div_by_zero;
    logic [IDX_W-1:0]         widx;

    // multiply path
    logic signed [DATA_W-1:0] mul_a;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] rounded;
    logic signed [DATA_W-1:0] addend;
    logic signed [SUM_W-1:0]  sum_w;
    logic signed [DATA_W-1:0] mul_result;
    logic                     mul_clamped;

    // divide path
    logic                     div_start;
    logic signed [DATA_W-1:0] div_quotient;
    div_status_t              div_status;

    // ------------------------------------------------------------------
    // Configuration registers. Weights beyond MAX_SOURCES are never used,
    // so writes to them are dropped.
    // ------------------------------------------------------------------
    always_comb
    begin
        op_next     = op_reg;
        weight_next = weight_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_OPERATION)
                op_next = cfg_data[OP_W-1:0];
            for (int k = 0; k < MAX_SOURCES; k++)
            begin
                if (cfg_index == CFG_INDEX_W'(int'(REG_WEIGHT_0) + k))
                    weight_next[k] = cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_first  = (src_reg == '0);
    // source 0 always counts; indexes past MAX_SOURCES are absent
    assign is_active = present_reg && (int'(src_reg) < MAX_SOURCES);
    assign widx      = is_active ? src_reg[IDX_W-1:0] : '0;

    assign div_by_zero = (x_reg == '0);

    always_comb
    begin
        go_mul = 1'b0;
        go_div = 1'b0;
        if (is_first)
            go_mul = (op_reg == OP_SUM);
        else if (is_active)
        begin
            go_mul = (op_reg == OP_SUM) || (op_reg == OP_PROD);
            go_div = (op_reg == OP_DIV) && !div_by_zero;
        end
    end

    // ------------------------------------------------------------------
    // Multiply, round half up, add, saturate
    // ------------------------------------------------------------------
    assign mul_a = (op_reg == OP_SUM) ? weight_reg[widx] : acc_reg;

    etc_mul u_mul (
        .clk         (clk),
        .a           (mul_a),
        .b           (x_reg),
        .product_reg (product_reg)
    );

    assign rounded = (product_reg + HALF_LSB) >>> FRACTION_BITS;
    assign addend  = (!is_first && op_reg == OP_SUM) ? acc_reg : '0;
    assign sum_w   = SUM_W'(rounded) + SUM_W'(addend);

    always_comb
    begin
        mul_clamped = 1'b1;
        if (sum_w > SUM_W'(Q_MAX))
            mul_result = Q_MAX;
        else if (sum_w < SUM_W'(Q_MIN))
            mul_result = Q_MIN;
        else
        begin
            mul_result  = sum_w[DATA_W-1:0];
            mul_clamped = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    assign div_start = (state_reg == ST_START) && go_div;

    etc_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (x_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (go_mul)
                    state_next = ST_MUL_FIN;
                else if (go_div)
                    state_next = ST_DIV_WAIT;
                else
                    state_next = ST_EMIT;
            end
            ST_MUL_FIN:
                state_next = ST_EMIT;
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!last_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall     = 1'b1;
        load_out     = 1'b0;
        x_next       = x_reg;
        src_next     = src_reg;
        present_next = present_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                x_next       = in_data.sample_value;
                src_next     = in_data.source_index;
                present_next = in_data.channel_present;
                last_next    = in_data.last_source;
            end
            ST_START:
            begin
                if (is_first)
                begin
                    sat_next = 1'b0;
                    if (op_reg != OP_SUM)
                        acc_next = x_reg;
                end
                else if (is_active)
                begin
                    case (op_reg)
                        OP_MAX:
                            acc_next = (x_reg > acc_reg) ? x_reg : acc_reg;
                        OP_MIN:
                            acc_next = (x_reg < acc_reg) ? x_reg : acc_reg;
                        OP_DIV:
                        begin
                            // divide by zero saturates toward the dividend sign
                            if (div_by_zero)
                            begin
                                sat_next = 1'b1;
                                if (acc_reg > 0)
                                    acc_next = Q_MAX;
                                else if (acc_reg < 0)
                                    acc_next = Q_MIN;
                                else
                                    acc_next = '0;
                            end
                        end
                        default:
                            acc_next = acc_reg;
                    endcase
                end
            end
            ST_MUL_FIN:
            begin
                acc_next = mul_result;
                sat_next = sat_reg | mul_clamped;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    acc_next = div_quotient;
                    sat_next = sat_reg | div_status.overflow;
                end
            end
            ST_EMIT:
                load_out = last_reg && out_free;
            default:
                in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next             = 1'b1;
            out_data_next.result_value = acc_reg;
            out_data_next.saturated    = sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SUM;
            for (int k = 0; k < MAX_SOURCES; k++)
                weight_reg[k] <= ONE_Q;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            weight_reg    <= weight_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        src_reg      <= src_next;
        present_reg  <= present_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_div_done_in_wait, div_status.done, state_reg == ST_DIV_WAIT)
    `ASSERT_NEXT(a_div_zero_flags, (state_reg == ST_START) && !is_first && is_active && (op_reg == OP_DIV) && div_by_zero, sat_reg)
    `ASSERT_NEXT(a_first_clears_flag, (state_reg == ST_START) && is_first && (op_reg != OP_SUM), !sat_reg)

endmodule

### sim/etc_checker.sv
// ----------------------------------------------------------------------------
// etc_checker
// Watches the register port and both channels of the elementwise tensor
// combiner. It keeps its own copy of the registers, the accumulator and the
// saturation flag, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module etc_checker #(
    parameter int MAX_SRC = etc_pkg::MAX_SOURCES_DEF,
    parameter int FRAC    = etc_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [etc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [etc_pkg::DATA_W-1:0]      cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  etc_pkg::in_item_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  etc_pkg::out_item_t              out_data,
    output int                              errors,
    output int                              pending,
    output int                              results,
    output int                              flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    import etc_pkg::*;

    localparam int REPORT_CAP = 40;

    logic [OP_W-1:0]          op_sel;
    logic signed [DATA_W-1:0] weight_q [4];
    logic signed [DATA_W-1:0] acc_q;
    bit                       sat_seen;
    out_item_t                results_due [$];
    int                       err_n;
    int                       result_n;
    int                       flag_n;

    // Q(2F) -> QF, half an LSB added, then floor
    function automatic longint round_half_up(input longint p);
        return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v, inout bit hit);
        if (v > longint'(Q_MAX))
        begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    task automatic fold_sample(input in_item_t it);
        longint    x;
        longint    a;
        bit        hit;
        out_item_t r;
        x   = longint'($signed(it.sample_value));
        a   = longint'(acc_q);
        hit = 1'b0;
        if (it.source_index == '0)
        begin
            // source 0 always loads, present or not
            sat_seen = 1'b0;
            if (op_sel == OP_SUM)
                acc_q = clamp_q(round_half_up(longint'(weight_q[0]) * x), hit);
            else
                acc_q = it.sample_value;
        end
        else if (it.channel_present && int'(it.source_index) < MAX_SRC)
        begin
            case (op_sel)
                OP_PROD: acc_q = clamp_q(round_half_up(a * x), hit);
                OP_SUM:
                    acc_q = clamp_q(a + round_half_up(longint'(weight_q[it.source_index]) * x),
                                    hit);
                OP_MAX:  if (x > a) acc_q = it.sample_value;
                OP_MIN:  if (x < a) acc_q = it.sample_value;
                OP_DIV:
                begin
                    if (x == 0)
                    begin
                        hit   = 1'b1;
                        acc_q = (a > 0) ? Q_MAX : ((a < 0) ? Q_MIN : '0);
                    end
                    else
                        acc_q = clamp_q((a <<< FRAC) / x, hit);
                end
                default: ;  // spare codes: later sources are ignored
            endcase
        end
        sat_seen = sat_seen | hit;
        if (it.last_source)
        begin
            r.result_value = acc_q;
            r.saturated    = sat_seen;
            results_due.insert(results_due.size(), r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_sel   = OP_SUM;
            for (int k = 0; k < 4; k++)
                weight_q[k] = 32'sd1 <<< FRAC;
            acc_q    = '0;
            sat_seen = 1'b0;
            results_due.delete();
            err_n    = 0;
            result_n = 0;
            flag_n   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_OPERATION)
                    op_sel = cfg_data[OP_W-1:0];
                else if (cfg_index >= REG_WEIGHT_0 && cfg_index <= REG_WEIGHT_0 + 3)
                    weight_q[cfg_index - REG_WEIGHT_0] = cfg_data;
            end

            // result side first, so a transaction taken at this edge cannot match it
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    err_n++;
                    if (err_n <= REPORT_CAP)
                        $display("%0t: unexpected result: expected none, actual %h sat %b",
                                 $time, out_data.result_value, out_data.saturated);
                end
                else
                begin
                    out_item_t want;
                    want = results_due.pop_front();
                    result_n++;
                    if (out_data.saturated)
                        flag_n++;
                    if (out_data.result_value !== want.result_value)
                    begin
                        err_n++;
                        if (err_n <= REPORT_CAP)
                            $display("%0t: result_value mismatch: expected %h, actual %h",
                                     $time, want.result_value, out_data.result_value);
                    end
                    if (out_data.saturated !== want.saturated)
                    begin
                        err_n++;
                        if (err_n <= REPORT_CAP)
                            $display("%0t: saturated mismatch: expected %b, actual %b",
                                     $time, want.saturated, out_data.saturated);
                    end
                end
            end

            if (in_valid && !in_stall)
                fold_sample(in_data);
        end
        errors  <= err_n;
        pending <= results_due.size();
        results <= result_n;
        flagged <= flag_n;
    end

endmodule

### sim/tb_elementwise_tensor_combine.sv
// ----------------------------------------------------------------------------
// tb_elementwise_tensor_combine
// Stimulus and verdict for the elementwise tensor combiner. A short directed
// pass hits saturation, divide by zero, absent channels and a spare operation
// code; then random elements run under a series of register settings while
// both channels idle and stall at random. etc_checker does the predicting.
// ----------------------------------------------------------------------------
module tb_elementwise_tensor_combine;
    timeunit 1ns;
    timeprecision 1ps;

    import etc_pkg::*;

    // operation codes the block does not define; they must load and then hold
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int N_PHASES        = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 60;      // longer than a division
    localparam int DRAIN_LIMIT     = 20000;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;

    int errors;
    int pending;
    int results;
    int flagged;

    int  cycle_n;
    int  items_sent;
    int  settings_n;
    int  stall_left;
    int  stall_pick;
    bit  steady;            // no gaps and no stalls while set
    logic [OP_W-1:0] op_plan [N_PHASES];

    elementwise_tensor_combine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    etc_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending),
        .results   (results),
        .flagged   (flagged)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_n, pending);
            $display("tb_elementwise_tensor_combine: FAIL");
            $finish;
        end
    end

    // Result-side back-pressure: short stalls, some long ones, and
    // occasional long stretches with the channel wide open.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (steady)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end
            else if (stall_pick < 85)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(30, 80);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 60);
            end
        end
    end

    // Sample mix: small Q16.16 magnitudes keep products and quotients in
    // range, the rest is raw noise, zeros (divide by zero) and range edges.
    function automatic logic [DATA_W-1:0] rand_value();
        logic [DATA_W-1:0] v;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            v = $urandom_range(0, 32'h0004_0000);
        else if (pick < 45)
            v = $urandom_range(0, 255);
        else if (pick < 75)
            v = $urandom();
        else if (pick < 83)
            v = '0;
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0001_0000;
                3:       v = 32'hFFFF_0000;
                4:       v = 32'h0000_0001;
                default: v = 32'hFFFF_FFFF;
            endcase
            return v;
        end
        if (pick < 45 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // weight set per phase: unit, small signed, raw random, extremes
    function automatic logic [DATA_W-1:0] weight_for(input int mode, input int k);
        logic [DATA_W-1:0] w;
        case (mode)
            0: w = 32'h0001_0000;
            1:
            begin
                w = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1))
                    w = -w;
            end
            2: w = $urandom();
            default:
            begin
                case (k)
                    0:       w = 32'h7FFF_FFFF;
                    1:       w = 32'h8000_0000;
                    2:       w = 32'h0000_0000;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic int pick_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_item_t mk(input logic [DATA_W-1:0] v, input int src,
                                    input bit present, input bit last);
        in_item_t it;
        it.sample_value    = v;
        it.source_index    = src[SRC_W-1:0];
        it.channel_present = present;
        it.last_source     = last;
        return it;
    endfunction

    // One transaction. With no gap, valid simply stays high for the next one.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // One output element: sources 0..n-1 in order, last on the final one.
    // Some elements are scrambled: any source order, random last flags.
    task automatic send_element();
        int       n;
        bit       scrambled;
        in_item_t it;
        n         = $urandom_range(1, 4);
        scrambled = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < n; k++)
        begin
            it.sample_value = rand_value();
            if (scrambled)
            begin
                it.source_index    = $urandom_range(0, 3);
                it.channel_present = $urandom_range(0, 1);
                it.last_source     = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                it.source_index    = k[SRC_W-1:0];
                it.channel_present = (k == 0) ? $urandom_range(0, 1)
                                              : ($urandom_range(0, 4) != 0);
                it.last_source     = (k == n - 1);
            end
            send_item(it);
        end
    endtask

    // Wait for every expected result, then for any element still being
    // worked on without a result, before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_block(input logic [OP_W-1:0] op, input int wmode);
        write_reg(REG_OPERATION, DATA_W'(op));
        for (int k = 0; k < 4; k++)
            write_reg(REG_WEIGHT_0 + CFG_INDEX_W'(k), weight_for(wmode, k));
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    initial
    begin
        int phase_start;
        int waited;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cycle_n    = 0;
        items_sent = 0;
        settings_n = 1;     // the reset values count as the first setting
        steady     = 1'b0;
        op_plan = '{OP_SUM, OP_PROD, OP_MAX, OP_DIV, OP_MIN, OP_SUM, OP_SPARE_HI,
                    OP_DIV, OP_SUM, OP_PROD, OP_MIN, OP_SPARE_LO, OP_SUM, OP_MAX};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset setting is weighted sum with unit weights ---
        // later source before any load folds into the zero accumulator
        send_item(mk(32'h0001_8000, 1, 1'b1, 1'b1));
        // sum overflows and saturates
        send_item(mk(32'h7FFF_FFFF, 0, 1'b1, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 1, 1'b1, 1'b1));
        // source 0 loads even when marked absent; absent later sources skip
        send_item(mk(32'h8000_0000, 0, 1'b0, 1'b0));
        send_item(mk(32'h0000_0000, 2, 1'b0, 1'b0));
        send_item(mk(32'h1234_5678, 3, 1'b0, 1'b1));

        // divide by zero with positive, negative and zero dividend,
        // then the most negative value over the smallest negative step
        settle();
        program_block(OP_DIV, 0);
        send_item(mk(32'h0005_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'h0000_0000, 1, 1'b1, 1'b1));
        send_item(mk(32'hFFFD_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'h0000_0000, 1, 1'b1, 1'b1));
        send_item(mk(32'h0000_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'h0000_0000, 1, 1'b1, 1'b1));
        send_item(mk(32'h8000_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'hFFFF_FFFF, 1, 1'b1, 1'b1));

        // product overflow, then an exact chain with an absent source
        settle();
        program_block(OP_PROD, 2);
        send_item(mk(32'h7FFF_FFFF, 0, 1'b1, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 1, 1'b1, 1'b1));
        send_item(mk(32'h0001_8000, 0, 1'b1, 1'b0));
        send_item(mk(32'h0002_0000, 2, 1'b0, 1'b0));
        send_item(mk(32'hFFFF_0000, 3, 1'b1, 1'b1));

        settle();
        program_block(OP_MAX, 0);
        send_item(mk(32'hFFFF_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'h8000_0000, 1, 1'b1, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 2, 1'b1, 1'b1));

        settle();
        program_block(OP_MIN, 1);
        send_item(mk(32'hFFFF_0000, 0, 1'b1, 1'b0));
        send_item(mk(32'h8000_0000, 1, 1'b1, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 2, 1'b1, 1'b1));

        // spare code: load only, later sources ignored
        settle();
        program_block(OP_SPARE_HI, 3);
        send_item(mk(32'h0002_8000, 0, 1'b1, 1'b0));
        send_item(mk(32'h0001_0000, 1, 1'b1, 1'b1));

        // --- random: one register setting per phase ---
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            steady = (p % 5 == 2);
            program_block(op_plan[p], p % 4);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_element();
        end
        steady = 1'b0;

        // drain: bounded, so a lost result is reported rather than hung on
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d input transactions under %0d register settings",
                 items_sent, settings_n);
        $display("%0d results compared, %0d flagged saturated, %0d never arrived",
                 results, flagged, pending);
        if (errors == 0 && pending == 0)
            $display("tb_elementwise_tensor_combine: PASS");
        else
            $display("tb_elementwise_tensor_combine: FAIL");
        $finish;
    end

endmodule
